// ===== src/iocrob_pkg.sv =====
// ----------------------------------------------------------------------------
// iocrob_pkg
// shared widths, codes and controller/datapath interface types for the
// in-order completion reorder buffer
// ----------------------------------------------------------------------------
package iocrob_pkg;

    // window geometry
    localparam int SLOTS   = 8;
    localparam int MAX_RUN = 8;
    localparam int POS_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);

    // field widths
    localparam int IDX_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 26;
    localparam int CAUSE_W  = 2;

    // stream packing
    localparam int PAYLOAD_W = IDX_W + HANDLE_W + LEN_W;
    localparam int DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int USER_W    = 1 + CAUSE_W + 1;

    // result kinds
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_REJECT  = 1'b1;

    // reject causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_WINDOW = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_STALE  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_TOTAL  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture accepted input item
        logic store;       // write item into its slot, clear run count
        logic reject;      // load output register with a rejection
        logic release_rd;  // read head slot, advance next release
        logic load_out;    // load output register with the released entry
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rejected;    // captured item fails a window check
        logic head_ok;     // head slot may be released now
        logic rel_last;    // pending release ends the run
        logic out_free;    // output register can take a new result
    } dp_status_t;

endpackage

// ===== src/iocrob_ctrl.sv =====
// ----------------------------------------------------------------------------
// iocrob_ctrl
// sequencer: capture, check/store, then one release per read/load pair
// ----------------------------------------------------------------------------
module iocrob_ctrl
    import iocrob_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.rejected) begin
                    if (status.out_free) begin
                        cmd.reject = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.store  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.head_ok) begin
                    cmd.release_rd = 1'b1;
                    state_next     = ST_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = status.rel_last ? ST_IDLE : ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/iocrob_dp.sv =====
// ----------------------------------------------------------------------------
// iocrob_dp
// window state, slot memory, checks and output register
// ----------------------------------------------------------------------------
module iocrob_dp
    import iocrob_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [IDX_W-1:0]    total_blocks,
    input  logic [DATA_W-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,
    output logic [USER_W-1:0]   m_tuser,
    output logic                m_tlast
);

    // captured input item
    logic [IDX_W-1:0]    in_idx_reg;
    logic [HANDLE_W-1:0] in_handle_reg;
    logic [LEN_W-1:0]    in_len_reg;

    // window state
    logic [IDX_W-1:0]    next_rel_reg;
    logic [POS_W-1:0]    head_pos_reg;
    logic [SLOTS-1:0]    slot_ready_reg;
    logic [RUN_W-1:0]    run_cnt_reg;

    // slot memory {length, handle}
    logic [LEN_W+HANDLE_W-1:0] slot_mem [SLOTS];
    logic [LEN_W+HANDLE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rel_idx_reg;
    logic                      rel_last_reg;
    logic                      rel_done_reg;

    // output register
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [CAUSE_W-1:0]  out_cause_reg;
    logic                out_last_reg;
    logic                out_done_reg;

    logic [CAUSE_W-1:0]  cause;
    logic [IDX_W:0]      win_end;
    logic [IDX_W-1:0]    offset;
    logic [POS_W:0]      pos_sum;
    logic [POS_W-1:0]    store_pos;
    logic [POS_W-1:0]    head_pos_inc;
    logic [IDX_W:0]      rel_plus1;
    logic                rel_done;
    logic                out_free;

    // window checks, in priority order
    assign win_end = {1'b0, next_rel_reg} + (IDX_W+1)'(SLOTS);
    assign offset  = in_idx_reg - next_rel_reg;
    assign pos_sum = {1'b0, head_pos_reg} + {1'b0, offset[POS_W-1:0]};
    assign store_pos = (pos_sum >= (POS_W+1)'(SLOTS)) ?
                       POS_W'(pos_sum - (POS_W+1)'(SLOTS)) : pos_sum[POS_W-1:0];

    always_comb begin
        if (in_idx_reg >= total_blocks) begin
            cause = CAUSE_TOTAL;
        end else if (in_idx_reg < next_rel_reg) begin
            cause = CAUSE_STALE;
        end else if ({1'b0, in_idx_reg} >= win_end) begin
            cause = CAUSE_WINDOW;
        end else if (slot_ready_reg[store_pos]) begin
            cause = CAUSE_STALE;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    assign head_pos_inc = (head_pos_reg == POS_W'(SLOTS - 1)) ? '0 : head_pos_reg + 1'b1;
    assign rel_plus1    = {1'b0, next_rel_reg} + 1'b1;
    assign rel_done     = rel_plus1 >= {1'b0, total_blocks};
    assign out_free     = !out_valid_reg || m_tready;

    assign status.rejected = (cause != CAUSE_NONE);
    assign status.head_ok  = slot_ready_reg[head_pos_reg] && (next_rel_reg < total_blocks)
                             && (run_cnt_reg < RUN_W'(MAX_RUN));
    assign status.rel_last = rel_last_reg;
    assign status.out_free = out_free;

    // input capture and release bookkeeping (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_idx_reg    <= s_tdata[IDX_W-1:0];
            in_handle_reg <= s_tdata[IDX_W +: HANDLE_W];
            in_len_reg    <= s_tdata[IDX_W+HANDLE_W +: LEN_W];
        end
        if (cmd.store) begin
            slot_mem[store_pos] <= {in_len_reg, in_handle_reg};
        end
        if (cmd.release_rd) begin
            rd_data_reg  <= slot_mem[head_pos_reg];
            rel_idx_reg  <= next_rel_reg;
            rel_done_reg <= rel_done;
            rel_last_reg <= (run_cnt_reg == RUN_W'(MAX_RUN - 1)) || rel_done
                            || !slot_ready_reg[head_pos_inc];
        end
    end

    // window control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_rel_reg   <= '0;
            head_pos_reg   <= '0;
            slot_ready_reg <= '0;
            run_cnt_reg    <= '0;
        end else begin
            if (cmd.store) begin
                slot_ready_reg[store_pos] <= 1'b1;
                run_cnt_reg               <= '0;
            end
            if (cmd.release_rd) begin
                slot_ready_reg[head_pos_reg] <= 1'b0;
                next_rel_reg                 <= rel_plus1[IDX_W-1:0];
                head_pos_reg                 <= head_pos_inc;
                run_cnt_reg                  <= run_cnt_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.reject || cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.reject) begin
            out_kind_reg   <= KIND_REJECT;
            out_idx_reg    <= in_idx_reg;
            out_handle_reg <= in_handle_reg;
            out_len_reg    <= in_len_reg;
            out_cause_reg  <= cause;
            out_last_reg   <= 1'b1;
            out_done_reg   <= (next_rel_reg >= total_blocks);
        end else if (cmd.load_out) begin
            out_kind_reg   <= KIND_RELEASE;
            out_idx_reg    <= rel_idx_reg;
            out_handle_reg <= rd_data_reg[HANDLE_W-1:0];
            out_len_reg    <= rd_data_reg[HANDLE_W +: LEN_W];
            out_cause_reg  <= CAUSE_NONE;
            out_last_reg   <= rel_last_reg;
            out_done_reg   <= rel_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(DATA_W - PAYLOAD_W)'(0), out_len_reg, out_handle_reg, out_idx_reg};
    assign m_tuser  = {out_done_reg, out_cause_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    // a release only takes a slot that holds a stored item
    a_release_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.release_rd |-> slot_ready_reg[head_pos_reg])
        else $error("release of an empty slot");

    // each release advances the window by exactly one
    a_release_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.release_rd |=> next_rel_reg == $past(next_rel_reg) + 1'b1)
        else $error("next release did not advance by one");

    // a store never lands on an occupied slot or a rejected item
    a_store_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (!slot_ready_reg[store_pos] && cause == CAUSE_NONE))
        else $error("store into occupied slot or of rejected item");

    // a rejection leaves the window untouched
    a_reject_no_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reject |=> ($stable(next_rel_reg) && $stable(slot_ready_reg)))
        else $error("rejection changed window state");

    // results are never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.reject || cmd.load_out) |-> out_free)
        else $error("output register overwritten");

endmodule

// ===== src/in_order_completion_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// in_order_completion_reorder_buffer
// reorders out-of-order block completions into index order
// ----------------------------------------------------------------------------
// usage
//   input stream (s_*): one completed block per item, index, handle, length.
//   result stream (m_*): releases in index order, or one rejection per bad
//   item. tlast marks the final result caused by an input item.
//   apb port: register 0 at byte address 0 holds total_blocks (reset 65535).
//   write it only while the block is idle.
// sequencing
//   an item is captured on acceptance and checked/stored in the cycle after;
//   a rejected item is loaded into the output register from the check once
//   that register is free. a stored item then runs its releases: each
//   release reads the head slot from slot memory, then loads the output
//   register, holding while the receiver has not taken the previous result.
//   one input releases at most MAX_RUN slots.
//   the sequencer handles one item at a time: s_tready is high only while
//   it waits for the next item.
// reset
//   synchronous active-low aresetn empties the window, sets next release to
//   zero and drops m_tvalid. slot contents need no clearing.
// stalls
//   a waiting result sits in the output register; once the sequencer is
//   idle a new item is still accepted, and the sequencer holds before
//   loading the next result until the receiver takes the one in place.
// ----------------------------------------------------------------------------
module in_order_completion_reorder_buffer
    import iocrob_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // block_index, payload_handle, payload_length, pad

    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // out_index, out_handle, out_length, pad
    output logic [USER_W-1:0]   m_tuser,   // result_kind, reject_cause[1:0], all_done
    output logic                m_tlast,   // last_of_run

    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // word index of the total_blocks register
    localparam logic REG_TOTAL = 1'b0;

    logic [IDX_W-1:0] total_reg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // apb: zero wait states, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 16'hFFFF;
        end else if (cfg_wr && paddr[2] == REG_TOTAL) begin
            total_reg <= pwdata[IDX_W-1:0];
        end
    end

    // unmapped word reads back as zero
    assign prdata = (paddr[2] == REG_TOTAL) ? {(32 - IDX_W)'(0), total_reg} : 32'd0;

    // sequencer
    iocrob_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // window state, slot memory and output register
    iocrob_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .total_blocks (total_reg),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
